### rtl/ictf_pkg.sv
`timescale 1ns / 1ps
// ictf_pkg: shared constants, register indexes and the arctangent table
// for the complementary tilt filter. No dependencies.
package ictf_pkg;

    localparam int CordicIterDefault = 16;
    localparam int AtanLen           = 24;
    localparam int CordicW           = 36;   // CORDIC x/y datapath width
    localparam int AngW              = 32;
    localparam int SqrtSteps         = 32;   // result bits of the root
    localparam int DivNumW           = 48;   // rounded gyro numerator
    localparam int DivQW             = 22;   // gyro increment magnitude
    localparam int DivRemW           = 27;
    localparam int CfgIdxW           = 8;

    localparam logic signed [AngW-1:0] Deg90 = 32'sd5898240;
    localparam logic [DivRemW-1:0]     GyroDiv  = 27'd131000000;
    localparam logic [DivNumW-1:0]     GyroHalf = 48'd65500000;
    localparam logic [15:0]            AlphaReset = 16'd64225;

    localparam logic [CfgIdxW-1:0] REG_ALPHA = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_OFS_X = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_OFS_Y = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_OFS_Z = 8'd3;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/ictf_if.sv
`timescale 1ns / 1ps
// ictf interfaces: sample input, attitude output and register write channels.
// Depends on ictf_pkg.
interface ictf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        step_time_us;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    step_time_us, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  step_time_us, output ready);
endinterface

interface ictf_attitude_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface ictf_cfg_if;
    import ictf_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [15:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/ictf_sqrt.sv
`timescale 1ns / 1ps
// ictf_sqrt: bit-serial integer root of (s << 32), one result bit per cycle.
// Depends on ictf_pkg.
module ictf_sqrt
    import ictf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          s,
    output logic                 busy,
    output logic [SqrtSteps-1:0] root
);
    localparam int CntW = $clog2(SqrtSteps);

    logic                   busy_reg;
    logic [CntW-1:0]        cnt_reg;
    logic [2*SqrtSteps-1:0] rad_reg;
    logic [SqrtSteps+2:0]   rem_reg;
    logic [SqrtSteps-1:0]   root_reg;

    logic [SqrtSteps+2:0] rem_sh;
    logic [SqrtSteps+2:0] trial;

    assign rem_sh = {rem_reg[SqrtSteps:0], rad_reg[2*SqrtSteps-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CntW'(SqrtSteps - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {s, 32'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[2*SqrtSteps-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[SqrtSteps-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SqrtSteps-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

### rtl/ictf_div.sv
`timescale 1ns / 1ps
// ictf_div: division by the fixed gyro divisor through a reciprocal multiply and one
// correction step, on a single shared multiplier. Depends on ictf_pkg.
module ictf_div
    import ictf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DivNumW-1:0] num,
    output logic               busy,
    output logic [DivQW-1:0]   quot
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EST  = 2'd1;
    localparam logic [1:0] PH_BACK = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;
    localparam int HiLsb = DivNumW - DivQW;
    // floor(2^58 / divisor): upper numerator bits times this, >> 32, gives the
    // quotient or one less
    localparam logic [31:0] Recip = 32'd2200231879;

    logic [1:0]         phase_reg;
    logic [DivNumW-1:0] num_reg;
    logic [DivQW-1:0]   quot_reg;
    logic [DivQW+31:0]  prod_reg;

    logic [DivQW-1:0]   mul_a;
    logic [31:0]        mul_b;
    logic [DivQW+31:0]  prod;
    logic [DivNumW-1:0] rem;

    assign mul_a = (phase_reg == PH_EST) ? num_reg[DivNumW-1:HiLsb] : quot_reg;
    assign mul_b = (phase_reg == PH_EST) ? Recip : 32'(GyroDiv);
    assign prod  = mul_a * mul_b;
    assign rem   = num_reg - prod_reg[DivNumW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else if (start)
            phase_reg <= PH_EST;
        else
        begin
            case (phase_reg)
                PH_EST:  phase_reg <= PH_BACK;
                PH_BACK: phase_reg <= PH_FIX;
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            num_reg <= num;
        else
        begin
            case (phase_reg)
                PH_EST:  quot_reg <= prod[DivQW+31:32];
                PH_BACK: prod_reg <= prod;
                PH_FIX:
                begin
                    if (rem >= DivNumW'(GyroDiv))
                        quot_reg <= quot_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign busy = (phase_reg != PH_IDLE);
    assign quot = quot_reg;
endmodule

### rtl/ictf_cordic.sv
`timescale 1ns / 1ps
// ictf_cordic: iterative CORDIC vectoring atan2, one micro-rotation per cycle.
// Depends on ictf_pkg.
module ictf_cordic
    import ictf_pkg::*;
#(
    parameter int ITERATIONS = CordicIterDefault
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [CordicW-1:0] x0,
    input  logic signed [CordicW-1:0] y0,
    output logic                      busy,
    output logic signed [AngW-1:0]    ang
);
    localparam int CntW = $clog2(ITERATIONS);

    logic                      busy_reg;
    logic [CntW-1:0]           cnt_reg;
    logic signed [CordicW-1:0] x_reg;
    logic signed [CordicW-1:0] y_reg;
    logic signed [AngW-1:0]    ang_reg;
    logic                      zero_reg;

    logic signed [CordicW-1:0] xs;
    logic signed [CordicW-1:0] ys;
    logic signed [AngW-1:0]    step;

    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign step = $signed({10'd0, atan_entry(5'(cnt_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CntW'(ITERATIONS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x0 == '0) && (y0 == '0);
            // left half plane: turn by 90 degrees first
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_reg   <= y0;
                    y_reg   <= -x0;
                    ang_reg <= Deg90;
                end
                else
                begin
                    x_reg   <= -y0;
                    y_reg   <= x0;
                    ang_reg <= -Deg90;
                end
            end
            else
            begin
                x_reg   <= x0;
                y_reg   <= y0;
                ang_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                ang_reg <= ang_reg + step;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                ang_reg <= ang_reg - step;
            end
        end
    end

    assign busy = busy_reg;
    assign ang  = zero_reg ? '0 : ang_reg;
endmodule

### rtl/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// imu_complementary_tilt_filter: top level, sequencer, blend datapath and registers.
// Depends on ictf_pkg, ictf_if, ictf_sqrt, ictf_div, ictf_cordic.
//
// Usage:
//   sample    - one raw six-axis sample plus elapsed microseconds per transaction.
//   attitude  - one result per sample: roll, pitch, yaw in Q16.16 degrees.
//   cfg       - register writes (0 alpha, 1..3 gyro offsets x/y/z), always ready;
//               other indexes are dropped. Write only while the block is idle.
//   One sample is processed at a time; sample.ready is high only when idle.
//   After the sample transaction the sequencer runs the bit-serial root, the
//   shared CORDIC unit (roll, then pitch), the reciprocal divider for each gyro
//   axis and the two blends, then loads the output register and raises
//   attitude.valid. A new sample is taken only after that load.
//   The result sits in an output register; a stalled receiver holds it, and the
//   next sample is accepted and processed meanwhile, waiting only to deliver.
//   Reset clears the angles to zero, alpha to 64225 and the offsets to zero.
module imu_complementary_tilt_filter
    import ictf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    ictf_sample_if.sink     sample,
    ictf_attitude_if.source attitude,
    ictf_cfg_if.sink        cfg
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_RUN1  = 4'd2;
    localparam logic [3:0] ST_WAIT1 = 4'd3;
    localparam logic [3:0] ST_RUN2  = 4'd4;
    localparam logic [3:0] ST_WAIT2 = 4'd5;
    localparam logic [3:0] ST_RUN3  = 4'd6;
    localparam logic [3:0] ST_WAIT3 = 4'd7;
    localparam logic [3:0] ST_BLA   = 4'd8;
    localparam logic [3:0] ST_BLB   = 4'd9;
    localparam logic [3:0] ST_BLC   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [15:0]        alpha_reg;
    logic signed [15:0] ofs_x_reg;
    logic signed [15:0] ofs_y_reg;
    logic signed [15:0] ofs_z_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0]        dt_reg;

    logic [31:0]               s_reg;
    logic [DivNumW-1:0]        m_reg;
    logic                      neg_reg;
    logic signed [DivQW:0]     dx_reg, dy_reg, dz_reg;
    logic signed [AngW-1:0]    roll_tilt_reg, pitch_tilt_reg;
    logic signed [AngW-1:0]    roll_reg, pitch_reg, yaw_reg;
    logic                      bsel_reg;
    logic signed [50:0]        p_reg;
    logic signed [49:0]        q_reg;

    logic                      out_valid_reg;
    logic signed [AngW-1:0]    roll_out_reg, pitch_out_reg, yaw_out_reg;

    logic                      sqrt_busy, div_busy, cordic_busy;
    logic [SqrtSteps-1:0]      root;
    logic [DivQW-1:0]          quot;
    logic signed [AngW-1:0]    cordic_ang;
    logic                      cordic_start, div_start, sqrt_start;
    logic signed [CordicW-1:0] cx0, cy0;
    logic                      units_idle;

    // gyro numerator for the selected axis
    logic signed [15:0] g_sel, o_sel;
    logic signed [16:0] g_diff;
    logic signed [33:0] g_prod;
    logic [31:0]        g_mag;
    logic signed [DivQW:0] delta;

    // blend
    logic signed [AngW-1:0] ang_sel, acc_sel;
    logic signed [DivQW:0]  dsel;
    logic signed [33:0]     prop;
    logic [16:0]            beta;
    logic signed [51:0]     bsum;
    logic signed [35:0]     bshr;
    logic signed [AngW-1:0] bsat;
    logic                   out_free;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign units_idle   = !sqrt_busy && !div_busy && !cordic_busy;
    assign out_free     = !out_valid_reg || attitude.ready;

    assign sqrt_start   = (state_reg == ST_RUN1);
    assign cordic_start = (state_reg == ST_RUN1) || (state_reg == ST_RUN2);
    assign div_start    = (state_reg == ST_RUN1) || (state_reg == ST_RUN2) ||
                          (state_reg == ST_RUN3);

    always_comb
    begin
        if (state_reg == ST_RUN1)
        begin
            cx0 = CordicW'($signed({az_reg, 16'd0}));
            cy0 = CordicW'($signed({ay_reg, 16'd0}));
        end
        else
        begin
            cx0 = $signed({{(CordicW - SqrtSteps){1'b0}}, root});
            cy0 = -CordicW'($signed({ax_reg, 16'd0}));
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_PREP:
            begin
                g_sel = gx_reg;
                o_sel = ofs_x_reg;
            end
            ST_WAIT1:
            begin
                g_sel = gy_reg;
                o_sel = ofs_y_reg;
            end
            default:
            begin
                g_sel = gz_reg;
                o_sel = ofs_z_reg;
            end
        endcase
    end

    assign g_diff = 17'(g_sel) - 17'(o_sel);
    assign g_prod = g_diff * $signed({1'b0, dt_reg});
    assign g_mag  = g_prod[33] ? 32'(-g_prod) : 32'(g_prod);
    assign delta  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    assign ang_sel = bsel_reg ? pitch_reg : roll_reg;
    assign acc_sel = bsel_reg ? pitch_tilt_reg : roll_tilt_reg;
    assign dsel    = bsel_reg ? dy_reg : dx_reg;
    assign prop    = 34'(ang_sel) + 34'(dsel);
    assign beta    = 17'd65536 - {1'b0, alpha_reg};
    assign bsum    = 52'(p_reg) + 52'(q_reg) + 52'sd32768;
    assign bshr    = bsum[51:16];

    always_comb
    begin
        if (bshr > 36'sh0_7FFF_FFFF)
            bsat = 32'sh7FFF_FFFF;
        else if (bshr < -36'sh0_8000_0000)
            bsat = -32'sh8000_0000;
        else
            bsat = bshr[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (sample.valid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_RUN1;
            ST_RUN1:  state_next = ST_WAIT1;
            ST_WAIT1: if (units_idle) state_next = ST_RUN2;
            ST_RUN2:  state_next = ST_WAIT2;
            ST_WAIT2: if (units_idle) state_next = ST_RUN3;
            ST_RUN3:  state_next = ST_WAIT3;
            ST_WAIT3: if (units_idle) state_next = ST_BLA;
            ST_BLA:   state_next = ST_BLB;
            ST_BLB:   state_next = ST_BLC;
            ST_BLC:   state_next = bsel_reg ? ST_OUT : ST_BLA;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= AlphaReset;
            ofs_x_reg     <= '0;
            ofs_y_reg     <= '0;
            ofs_z_reg     <= '0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
            bsel_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ALPHA: alpha_reg <= cfg.data;
                    REG_OFS_X: ofs_x_reg <= cfg.data;
                    REG_OFS_Y: ofs_y_reg <= cfg.data;
                    REG_OFS_Z: ofs_z_reg <= cfg.data;
                    default:   ;
                endcase
            end
            if (state_reg == ST_BLC)
            begin
                if (bsel_reg)
                    pitch_reg <= bsat;
                else
                    roll_reg <= bsat;
                bsel_reg <= !bsel_reg;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                yaw_reg       <= yaw_reg + AngW'(dz_reg);
                out_valid_reg <= 1'b1;
            end
            else if (attitude.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample.valid)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            az_reg <= sample.accel_z;
            gx_reg <= sample.gyro_x;
            gy_reg <= sample.gyro_y;
            gz_reg <= sample.gyro_z;
            dt_reg <= sample.step_time_us;
        end
        if (state_reg == ST_PREP)
            s_reg <= 32'(ay_reg * ay_reg) + 32'(az_reg * az_reg);
        if (state_reg == ST_PREP || (state_reg == ST_WAIT1 && units_idle) ||
            (state_reg == ST_WAIT2 && units_idle))
        begin
            m_reg   <= {g_mag, 16'd0} + GyroHalf;
            neg_reg <= g_prod[33];
        end
        if (state_reg == ST_WAIT1 && units_idle)
        begin
            roll_tilt_reg <= cordic_ang;
            dx_reg        <= delta;
        end
        if (state_reg == ST_WAIT2 && units_idle)
        begin
            pitch_tilt_reg <= cordic_ang;
            dy_reg         <= delta;
        end
        if (state_reg == ST_WAIT3 && units_idle)
            dz_reg <= delta;
        if (state_reg == ST_BLA)
            p_reg <= $signed({1'b0, alpha_reg}) * prop;
        if (state_reg == ST_BLB)
            q_reg <= $signed({1'b0, beta}) * acc_sel;
        if (state_reg == ST_OUT && out_free)
        begin
            roll_out_reg  <= roll_reg;
            pitch_out_reg <= pitch_reg;
            yaw_out_reg   <= yaw_reg + AngW'(dz_reg);
        end
    end

    assign attitude.valid     = out_valid_reg;
    assign attitude.roll_deg  = roll_out_reg;
    assign attitude.pitch_deg = pitch_out_reg;
    assign attitude.yaw_deg   = yaw_out_reg;

    ictf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .s     (s_reg),
        .busy  (sqrt_busy),
        .root  (root)
    );

    ictf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (m_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    ictf_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x0    (cx0),
        .y0    (cy0),
        .busy  (cordic_busy),
        .ang   (cordic_ang)
    );
endmodule
